// ===== rtl/core/spbd_pkg.sv =====
// ----------------------------------------------------------------------------
// spbd_pkg: shared types, constants and code tables
// Holds the result record, the status codes and the static prefix code tables
// of the short prefix bit decoder.
// ----------------------------------------------------------------------------
package spbd_pkg;

    localparam int ACC_W      = 13;
    localparam int CNT_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW   = $clog2(QUEUE_DEPTH + 1);

    // token lengths that can complete a token
    localparam logic [CNT_W-1:0] LEN_SHORT   = 4'd3;
    localparam logic [CNT_W-1:0] LEN_MID     = 4'd4;
    localparam logic [CNT_W-1:0] LEN_LONG    = 4'd6;
    localparam logic [CNT_W-1:0] LEN_LITERAL = 4'd13;

    localparam logic [2:0] SHORT_CODES = 3'd5;     // 000..100
    localparam logic [2:0] MID_PREFIX  = 3'b101;   // 1010, 1011
    localparam logic [5:0] LONG_FIRST  = 6'd48;    // 110000
    localparam logic [5:0] LONG_LAST   = 6'd61;    // 111101

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_NONCANON = 2'd2,
        ST_LIMIT    = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] decoded_byte;
        logic              byte_present;
        logic              message_end;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_push;

    function automatic logic [BYTE_W-1:0] tab_short(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = 8'h20;  // space
            3'd1:    b = 8'h65;  // e
            3'd2:    b = 8'h74;  // t
            3'd3:    b = 8'h61;  // a
            3'd4:    b = 8'h6F;  // o
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] tab_mid(input logic idx);
        return idx ? 8'h6E : 8'h69;  // n, i
    endfunction

    function automatic logic [BYTE_W-1:0] tab_long(input logic [3:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            4'd0:    b = 8'h73;  // s
            4'd1:    b = 8'h68;  // h
            4'd2:    b = 8'h72;  // r
            4'd3:    b = 8'h64;  // d
            4'd4:    b = 8'h6C;  // l
            4'd5:    b = 8'h75;  // u
            4'd6:    b = 8'h63;  // c
            4'd7:    b = 8'h6D;  // m
            4'd8:    b = 8'h66;  // f
            4'd9:    b = 8'h77;  // w
            4'd10:   b = 8'h79;  // y
            4'd11:   b = 8'h70;  // p
            4'd12:   b = 8'h62;  // b
            4'd13:   b = 8'h67;  // g
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // true for every byte that owns a code shorter than the literal escape
    function automatic logic has_short_code(input logic [BYTE_W-1:0] b);
        logic hit;
        unique case (b) inside
            8'h20, 8'h65, 8'h74, 8'h61, 8'h6F, 8'h69, 8'h6E,
            8'h73, 8'h68, 8'h72, 8'h64, 8'h6C, 8'h75, 8'h63,
            8'h6D, 8'h66, 8'h77, 8'h79, 8'h70, 8'h62, 8'h67: hit = 1'b1;
            default:                                         hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== rtl/core/spbd_front.sv =====
// ----------------------------------------------------------------------------
// spbd_front: bit intake and token classification
// Shifts code bits into the token register, matches completed tokens, checks
// the byte limit and the literal rule, and pushes one result when due.
// ----------------------------------------------------------------------------
module spbd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_bit_valid,
    output logic                         o_bit_ready,
    input  logic                         i_code_bit,
    input  logic                         i_last_bit,
    input  logic                         i_cfg_valid,
    input  logic [spbd_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                         i_queue_full,
    output spbd_pkg::t_push              o_push
);

    logic [spbd_pkg::ACC_W-1:0]   r_acc,   n_acc;
    logic [spbd_pkg::CNT_W-1:0]   r_cnt,   n_cnt;
    logic [spbd_pkg::LIMIT_W-1:0] r_emit,  n_emit;
    logic                         r_disc,  n_disc;
    logic [spbd_pkg::LIMIT_W-1:0] r_limit;

    logic                         accept;
    logic [spbd_pkg::ACC_W-1:0]   shifted;
    logic [spbd_pkg::CNT_W-1:0]   cnt_inc;
    logic                         done;
    logic [spbd_pkg::BYTE_W-1:0]  byte_val;

    assign o_bit_ready = !i_queue_full;
    assign accept      = i_bit_valid && o_bit_ready;
    assign shifted     = {r_acc[spbd_pkg::ACC_W-2:0], i_code_bit};
    assign cnt_inc     = r_cnt + 1'b1;

    always_comb begin
        done     = 1'b0;
        byte_val = '0;
        unique case (cnt_inc)
            spbd_pkg::LEN_SHORT: begin
                if (shifted[2:0] < spbd_pkg::SHORT_CODES) begin
                    done     = 1'b1;
                    byte_val = spbd_pkg::tab_short(shifted[2:0]);
                end
            end
            spbd_pkg::LEN_MID: begin
                if (shifted[3:1] == spbd_pkg::MID_PREFIX) begin
                    done     = 1'b1;
                    byte_val = spbd_pkg::tab_mid(shifted[0]);
                end
            end
            spbd_pkg::LEN_LONG: begin
                if (shifted[5:0] >= spbd_pkg::LONG_FIRST &&
                    shifted[5:0] <= spbd_pkg::LONG_LAST) begin
                    done     = 1'b1;
                    byte_val = spbd_pkg::tab_long(shifted[3:0]);
                end
            end
            spbd_pkg::LEN_LITERAL: begin
                done     = 1'b1;
                byte_val = shifted[spbd_pkg::BYTE_W-1:0];
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_emit = r_emit;
        n_disc = r_disc;
        o_push = '0;
        o_push.result.status = spbd_pkg::ST_OK;
        if (accept) begin
            if (r_disc) begin
                // drop bits until the message closes
                if (i_last_bit) begin
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_emit = '0;
                    n_disc = 1'b0;
                end
            end else if (r_cnt == '0 && r_emit >= r_limit) begin
                o_push.valid               = 1'b1;
                o_push.result.message_end  = 1'b1;
                o_push.result.status       = spbd_pkg::ST_LIMIT;
                n_disc                     = 1'b1;
            end else if (done && cnt_inc == spbd_pkg::LEN_LITERAL &&
                         spbd_pkg::has_short_code(byte_val)) begin
                o_push.valid               = 1'b1;
                o_push.result.message_end  = 1'b1;
                o_push.result.status       = spbd_pkg::ST_NONCANON;
                n_acc                      = shifted;
                n_cnt                      = cnt_inc;
                n_disc                     = 1'b1;
            end else if (done) begin
                o_push.valid               = 1'b1;
                o_push.result.decoded_byte = byte_val;
                o_push.result.byte_present = 1'b1;
                o_push.result.message_end  = i_last_bit;
                n_acc                      = '0;
                n_cnt                      = '0;
                n_emit                     = r_emit + 1'b1;
            end else if (i_last_bit) begin
                o_push.valid               = 1'b1;
                o_push.result.message_end  = 1'b1;
                o_push.result.status       = spbd_pkg::ST_TRUNC;
            end else begin
                n_acc = shifted;
                n_cnt = cnt_inc;
            end
            // a closing bit clears the whole message state
            if (i_last_bit) begin
                n_acc  = '0;
                n_cnt  = '0;
                n_emit = '0;
                n_disc = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_cnt   <= '0;
            r_emit  <= '0;
            r_disc  <= 1'b0;
            r_limit <= '1;
        end else begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_emit <= n_emit;
            r_disc <= n_disc;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

endmodule

// ===== rtl/core/spbd_queue.sv =====
// ----------------------------------------------------------------------------
// spbd_queue: result queue and output stage
// Small register FIFO between classification and the result stream; its head
// entry drives the output channel.
// ----------------------------------------------------------------------------
module spbd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spbd_pkg::t_push     i_push,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output spbd_pkg::t_result   o_result
);

    spbd_pkg::t_result                r_mem [spbd_pkg::QUEUE_DEPTH];
    logic [spbd_pkg::QUEUE_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [spbd_pkg::QUEUE_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [spbd_pkg::QUEUE_CW-1:0]    r_count,  n_count;
    logic                             pop;

    assign o_full   = (r_count == spbd_pkg::QUEUE_CW'(spbd_pkg::QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push.valid ? 1'b1 : 1'b0);
        n_rd_ptr = r_rd_ptr + (pop ? 1'b1 : 1'b0);
        n_count  = r_count;
        if (i_push.valid && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/core/short_prefix_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// short_prefix_bit_decoder: static prefix code decoder with literal escape
// Takes one code bit per request and returns one result per completed token
// or per error.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------
//  s_axis   | in        | s_axis_tvalid / _tready  | tdata[0] code bit, tlast last
//  m_axis   | out       | m_axis_tvalid / _tready  | tdata byte, tuser present+status,
//           |           |                          | tlast message end
//  cfg      | in        | i_cfg_valid / o_cfg_ready| byte limit, 32 bits
//  One code bit is taken every cycle while the result queue is not full;
//  classification of a bit finishes in the cycle it is accepted, and its
//  result is queued for m_axis behind older results. The 4-entry result
//  queue sets the stall point: s_axis_tready drops only while the queue is
//  full, so a slow result consumer stalls intake after four pending results.
//  Synchronous reset clears the decoder state and the queue and sets the byte
//  limit to all ones; the limit is written only through cfg and no message
//  end touches it.
// ----------------------------------------------------------------------------
module short_prefix_bit_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] code_bit, [7:1] zero fill
    input  logic        s_axis_tlast,   // last_bit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] decoded_byte
    output logic [2:0]  m_axis_tuser,   // [0] byte_present, [2:1] status
    output logic        m_axis_tlast,   // message_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data      // output_byte_limit
);

    spbd_pkg::t_push   push;
    spbd_pkg::t_result head;
    logic              queue_full;

    // the limit register takes a write in any cycle outside reset
    assign o_cfg_ready = 1'b1;

    // front: shift, match, check limit and literal rule
    spbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_valid  (s_axis_tvalid),
        .o_bit_ready  (s_axis_tready),
        .i_code_bit   (s_axis_tdata[0]),
        .i_last_bit   (s_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    // back: hold results until the consumer takes them
    spbd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (queue_full),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (head)
    );

    assign m_axis_tdata = head.decoded_byte;
    assign m_axis_tuser = {head.status, head.byte_present};
    assign m_axis_tlast = head.message_end;

endmodule

// ===== rtl/core/spbd_checker.sv =====
// ----------------------------------------------------------------------------
// spbd_checker: port-level checks for the decoder
// Watches the result stream for record consistency and reset behavior.
// ----------------------------------------------------------------------------
module spbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // an error record carries no byte and closes the message
    a_error_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && m_axis_tdata == 8'h00 &&
            m_axis_tuser[2:1] != spbd_pkg::ST_OK)
        else $error("malformed error result");

    // a byte record always has ok status
    a_byte_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == spbd_pkg::ST_OK)
        else $error("byte result with error status");

    // reset empties the result queue
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind short_prefix_bit_decoder spbd_checker u_spbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/short_prefix_bit_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_prefix_bit_decoder_tb: self-checking bench for the prefix bit decoder
// Streams code bits into the decoder and checks every result against a
// behavioral predictor. A directed table covers each code group, both literal
// extremes, truncation, noncanonical literals and the byte limit. Random
// messages follow under several byte limits and idle patterns.
// ----------------------------------------------------------------------------
module short_prefix_bit_decoder_tb;

    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before timeout
    localparam int SETTLE_CYCLES = 8;     // slack after the last result of a phase
    localparam int SEGMENT_BITS  = 200;   // code bits per random phase

    // Symbols in code order: 3-bit group, 4-bit group, 6-bit group.
    localparam string CODE_ALPHABET = " etaoinshrdlucmfwypbg";
    localparam int    MID_BASE      = 5;
    localparam int    LONG_BASE     = 7;

    typedef enum logic {
        ROW_BITS,
        ROW_LIMIT
    } t_row_kind;

    // One table row: a write of the byte limit, or a run of code bits sent
    // MSB first. A typed row carries the result its final bit must produce.
    typedef struct packed {
        t_row_kind          kind;
        logic [31:0]        value;
        logic [4:0]         len;
        logic               last;
        logic               typed;
        spbd_pkg::t_result  res;
    } t_stim_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata   = 8'd0;   // [0] code_bit, [7:1] zero fill
    logic        s_axis_tlast   = 1'b0;   // last_bit
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [7:0]  m_axis_tdata;            // [7:0] decoded_byte
    logic [2:0]  m_axis_tuser;            // [0] byte_present, [2:1] status
    logic        m_axis_tlast;            // message_end
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data     = 32'd0;  // output_byte_limit

    // Predictor state, mirrors the decoder after reset.
    logic [12:0] tok_acc   = '0;
    logic [3:0]  tok_len   = '0;
    logic [31:0] msg_bytes = '0;
    logic        dropping  = 1'b0;
    logic [31:0] byte_limit = 32'hFFFF_FFFF;

    spbd_pkg::t_result predicted_outputs [$];
    t_stim_row         directed_rows [$];
    logic              msg_bits [$];

    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int          sink_hold     = 0;
    int          bits_sent     = 0;
    int          errors        = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    logic [31:0] seg_limits [6] = '{32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFE,
                                   32'd0, 32'd1, 32'd6};

    short_prefix_bit_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void clear_message();
        tok_acc   = '0;
        tok_len   = '0;
        msg_bytes = '0;
        dropping  = 1'b0;
    endfunction

    // Error result; drop the rest of the message unless this is its last bit.
    function automatic logic flag_error(input spbd_pkg::t_status st, input logic last,
                                        output spbd_pkg::t_result r);
        r             = '0;
        r.message_end = 1'b1;
        r.status      = st;
        if (last) begin
            clear_message();
        end else begin
            dropping = 1'b1;
        end
        return 1'b1;
    endfunction

    // Advance the decoder by one code bit; return 1 when a result is due.
    function automatic logic decode_bit(input logic code, input logic last,
                                        output spbd_pkg::t_result r);
        logic [7:0] sym;
        logic       done;
        logic       noncanon;
        r        = '0;
        sym      = '0;
        done     = 1'b0;
        noncanon = 1'b0;
        if (dropping) begin
            if (last) begin
                clear_message();
            end
            return 1'b0;
        end
        // limit check runs only where a new token would begin
        if (tok_len == 0 && msg_bytes >= byte_limit) begin
            return flag_error(spbd_pkg::ST_LIMIT, last, r);
        end
        tok_acc = {tok_acc[11:0], code};
        tok_len = tok_len + 4'd1;
        case (tok_len)
            spbd_pkg::LEN_SHORT: begin
                if (tok_acc < 13'd5) begin
                    sym  = CODE_ALPHABET[tok_acc];
                    done = 1'b1;
                end
            end
            spbd_pkg::LEN_MID: begin
                if (tok_acc[3:1] == 3'b101) begin
                    sym  = CODE_ALPHABET[MID_BASE + tok_acc[0]];
                    done = 1'b1;
                end
            end
            spbd_pkg::LEN_LONG: begin
                if (tok_acc >= 13'd48 && tok_acc < 13'd62) begin
                    sym  = CODE_ALPHABET[LONG_BASE + tok_acc - 48];
                    done = 1'b1;
                end
            end
            spbd_pkg::LEN_LITERAL: begin
                sym  = tok_acc[7:0];
                done = 1'b1;
                for (int i = 0; i < CODE_ALPHABET.len(); i++) begin
                    if (CODE_ALPHABET[i] == sym) begin
                        noncanon = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (noncanon) begin
            return flag_error(spbd_pkg::ST_NONCANON, last, r);
        end
        if (done) begin
            msg_bytes      = msg_bytes + 32'd1;
            tok_acc        = '0;
            tok_len        = '0;
            r.decoded_byte = sym;
            r.byte_present = 1'b1;
            r.message_end  = last;
            r.status       = spbd_pkg::ST_OK;
            if (last) begin
                clear_message();
            end
            return 1'b1;
        end
        if (last) begin
            return flag_error(spbd_pkg::ST_TRUNC, 1'b1, r);
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic spbd_pkg::t_result mk_result(input logic [7:0] b,
                                                    input logic present,
                                                    input logic msg_end,
                                                    input spbd_pkg::t_status st);
        spbd_pkg::t_result r;
        r.decoded_byte = b;
        r.byte_present = present;
        r.message_end  = msg_end;
        r.status       = st;
        return r;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [31:0] value,
                                    input int len, input logic last,
                                    input logic typed, input spbd_pkg::t_result res);
        t_stim_row row;
        row.kind  = kind;
        row.value = value;
        row.len   = len[4:0];
        row.last  = last;
        row.typed = typed;
        row.res   = res;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Pick one complete token, at times a noncanonical literal: code right-aligned, length in bits.
    function automatic void random_token(output logic [12:0] code, output int len);
        int sel;
        sel = $urandom_range(99);
        if (sel < 35) begin
            code = 13'($urandom_range(4));
            len  = 3;
        end else if (sel < 55) begin
            code = 13'b1010 | 13'($urandom_range(1));
            len  = 4;
        end else if (sel < 82) begin
            code = 13'd48 + 13'($urandom_range(13));
            len  = 6;
        end else if (sel < 95) begin
            code = {5'b11111, 8'($urandom_range(255))};
            len  = 13;
        end else begin
            // literal escape around a symbol that owns a short code
            code = {5'b11111, 8'(CODE_ALPHABET[$urandom_range(20)])};
            len  = 13;
        end
    endfunction

    function automatic void append_token(input logic [12:0] code, input int len);
        for (int i = len - 1; i >= 0; i--) begin
            msg_bits.insert(msg_bits.size(), code[i]);
        end
    endfunction

    // Mostly well-formed messages; some cut inside the final token, some noise.
    function automatic void build_message();
        int          sel;
        int          n;
        int          cut;
        int          len;
        logic [12:0] code;
        msg_bits.delete();
        sel = $urandom_range(99);
        if (sel < 15) begin
            n = $urandom_range(1, 24);
            repeat (n) msg_bits.insert(msg_bits.size(), 1'($urandom_range(1)));
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                random_token(code, len);
                append_token(code, len);
            end
            if (sel < 27) begin
                random_token(code, len);
                cut = $urandom_range(1, len - 1);
                append_token(code >> cut, len - cut);
            end
        end
    endfunction

    // Offer one code bit from the falling edge; return at the accepting edge.
    task automatic push_bit(input logic code, input logic last, input logic typed,
                            input spbd_pkg::t_result typed_res);
        spbd_pkg::t_result r;
        logic              due;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, code};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        due = decode_bit(code, last, r);
        if (typed) begin
            predicted_outputs.insert(predicted_outputs.size(), typed_res);
        end else if (due) begin
            predicted_outputs.insert(predicted_outputs.size(), r);
        end
        bits_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bits.size(); i++) begin
            push_bit(msg_bits[i], i == msg_bits.size() - 1, 1'b0, '0);
        end
    endtask

    // Hold the input idle until every predicted result has been taken.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (predicted_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        byte_limit = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready, with a counted hold-off on request
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            m_axis_tready = 1'b0;
            sink_hold     = sink_hold - 1;
        end else begin
            m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        spbd_pkg::t_result seen;
        spbd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.decoded_byte = m_axis_tdata;
            seen.byte_present = m_axis_tuser[0];
            seen.message_end  = m_axis_tlast;
            seen.status       = spbd_pkg::t_status'(m_axis_tuser[2:1]);
            status_seen[int'(seen.status)]++;
            if (predicted_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result byte %02h present %0d end %0d status %0d",
                         $time, seen.decoded_byte, seen.byte_present,
                         seen.message_end, seen.status);
            end else begin
                want = predicted_outputs.pop_front();
                if (seen.decoded_byte !== want.decoded_byte ||
                    seen.byte_present !== want.byte_present ||
                    seen.message_end  !== want.message_end  ||
                    seen.status       !== want.status) begin
                    errors++;
                    $display("%0t: mismatch expected byte %02h present %0d end %0d status %0d",
                             $time, want.decoded_byte, want.byte_present,
                             want.message_end, want.status);
                    $display("%0t:          actual byte %02h present %0d end %0d status %0d",
                             $time, seen.decoded_byte, seen.byte_present,
                             seen.message_end, seen.status);
                end
            end
        end
    end

    // Timeout: too long without any handshake on any channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("short_prefix_bit_decoder_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        t_stim_row row;
        int        target;
        logic      hold_done;

        hold_done = 1'b0;

        // Directed table. Typed rows check the final bit against a fixed result.
        add_row(ROW_LIMIT, 32'hFFFF_FFFF, 0, 1'b0, 1'b0, '0);
        add_row(ROW_BITS, 32'b000, 3, 1'b0, 1'b1,
                mk_result(8'h20, 1'b1, 1'b0, spbd_pkg::ST_OK));
        add_row(ROW_BITS, 32'b100, 3, 1'b0, 1'b1,
                mk_result(8'h6F, 1'b1, 1'b0, spbd_pkg::ST_OK));
        add_row(ROW_BITS, 32'b1010, 4, 1'b0, 1'b1,
                mk_result(8'h69, 1'b1, 1'b0, spbd_pkg::ST_OK));
        add_row(ROW_BITS, 32'b1011, 4, 1'b0, 1'b1,
                mk_result(8'h6E, 1'b1, 1'b0, spbd_pkg::ST_OK));
        add_row(ROW_BITS, 32'b110000, 6, 1'b0, 1'b1,
                mk_result(8'h73, 1'b1, 1'b0, spbd_pkg::ST_OK));
        add_row(ROW_BITS, 32'b111101, 6, 1'b1, 1'b1,
                mk_result(8'h67, 1'b1, 1'b1, spbd_pkg::ST_OK));
        // literal extremes
        add_row(ROW_BITS, 32'h1F00, 13, 1'b0, 1'b1,
                mk_result(8'h00, 1'b1, 1'b0, spbd_pkg::ST_OK));
        add_row(ROW_BITS, 32'h1FFF, 13, 1'b1, 1'b1,
                mk_result(8'hFF, 1'b1, 1'b1, spbd_pkg::ST_OK));
        // literal 'e' is noncanonical; the bits after it are dropped
        add_row(ROW_BITS, 32'h1F65, 13, 1'b0, 1'b1,
                mk_result(8'h00, 1'b0, 1'b1, spbd_pkg::ST_NONCANON));
        add_row(ROW_BITS, 32'b1111, 4, 1'b0, 1'b0, '0);
        add_row(ROW_BITS, 32'b0, 1, 1'b1, 1'b0, '0);
        // messages ending inside a token
        add_row(ROW_BITS, 32'b11, 2, 1'b1, 1'b1,
                mk_result(8'h00, 1'b0, 1'b1, spbd_pkg::ST_TRUNC));
        add_row(ROW_BITS, 32'b1, 1, 1'b1, 1'b1,
                mk_result(8'h00, 1'b0, 1'b1, spbd_pkg::ST_TRUNC));
        add_row(ROW_BITS, 32'hF80, 12, 1'b1, 1'b1,
                mk_result(8'h00, 1'b0, 1'b1, spbd_pkg::ST_TRUNC));
        // plain literal, then a noncanonical one on the last bit itself
        add_row(ROW_BITS, 32'h1F5A, 13, 1'b0, 1'b0, '0);
        add_row(ROW_BITS, 32'h1F67, 13, 1'b1, 1'b1,
                mk_result(8'h00, 1'b0, 1'b1, spbd_pkg::ST_NONCANON));
        // lower the limit under a message already one byte in
        add_row(ROW_BITS, 32'b010, 3, 1'b0, 1'b0, '0);
        add_row(ROW_LIMIT, 32'd1, 0, 1'b0, 1'b0, '0);
        add_row(ROW_BITS, 32'b0, 1, 1'b0, 1'b1,
                mk_result(8'h00, 1'b0, 1'b1, spbd_pkg::ST_LIMIT));
        add_row(ROW_BITS, 32'b11, 2, 1'b1, 1'b0, '0);
        add_row(ROW_BITS, 32'b001, 3, 1'b1, 1'b0, '0);
        // zero limit rejects the very first bit
        add_row(ROW_LIMIT, 32'd0, 0, 1'b0, 1'b0, '0);
        add_row(ROW_BITS, 32'b1, 1, 1'b1, 1'b1,
                mk_result(8'h00, 1'b0, 1'b1, spbd_pkg::ST_LIMIT));

        // Hold reset, then release it at a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct  = 8;
        sink_idle_pct = 53;
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_LIMIT) begin
                settle();
                write_limit(row.value);
            end else begin
                for (int b = int'(row.len) - 1; b >= 0; b--) begin
                    push_bit(row.value[b], row.last && b == 0, row.typed && b == 0,
                             row.res);
                end
            end
        end

        // Random phases: sender-light/receiver-heavy idling, then the reverse,
        // then none. Each phase runs under its own byte limit.
        for (int seg = 0; seg < 6; seg++) begin
            settle();
            write_limit(seg_limits[seg]);
            src_idle_pct  = (seg < 2) ? 8 : (seg < 4) ? 53 : 0;
            sink_idle_pct = (seg < 2) ? 53 : (seg < 4) ? 8 : 0;
            target = bits_sent + SEGMENT_BITS;
            while (bits_sent < target) begin
                // Stall the receiver while the sender streams: fills the
                // result queue and forces the input to back up.
                if (seg == 5 && !hold_done && bits_sent > target - SEGMENT_BITS / 2) begin
                    sink_hold = 80;
                    hold_done = 1'b1;
                end
                build_message();
                send_message();
            end
        end

        settle();
        $display("Sent %0d code bits under six byte limits with three idle patterns.",
                 bits_sent);
        $display("Results: %0d bytes, %0d truncated, %0d noncanonical, %0d over limit.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0) begin
            $display("short_prefix_bit_decoder_tb passed");
        end else begin
            $display("short_prefix_bit_decoder_tb failed");
        end
        $finish;
    end

endmodule
